// ===== rtl/lipo_battery_gauge_macros.svh =====
// ----------------------------------------------------------------------------
// LiPo battery gauge assertion macros
// Shorthands for clocked, reset-qualified concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef LIPO_BATTERY_GAUGE_MACROS_SVH
`define LIPO_BATTERY_GAUGE_MACROS_SVH

// antecedent implies consequent in the same cycle
`define LPG_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define LPG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/lpg_pkg.sv =====
// ----------------------------------------------------------------------------
// lpg_pkg
// Shared types, constants and the charge ladder of the LiPo battery gauge.
// ----------------------------------------------------------------------------
package lpg_pkg;

    localparam int SAMPLE_W = 12;
    localparam int CFG_W    = 13;
    localparam int MV_W     = 15;
    localparam int CNT_W    = 3;
    localparam int PCT_W    = 7;
    localparam int ADDR_W   = 1;

    // mv = sample * 28000 / 4635 = sample * 5600 / 927
    localparam int MV_MUL_RED  = 5600;
    localparam int PROD_W      = 25;
    // ceil(2^35 / 927): exact floor division for every 25-bit product
    localparam int RECIP_W     = 26;
    localparam int RECIP_SHIFT = 35;
    localparam logic [RECIP_W-1:0] MV_RECIP = 26'd37065522;
    localparam int WIDE_W      = PROD_W + RECIP_W;

    localparam int DIV_CNT_W = 4;

    localparam logic [ADDR_W-1:0] REG_CELL_MIN = 1'd0;
    localparam logic [ADDR_W-1:0] REG_CELL_MAX = 1'd1;

    localparam logic [CFG_W-1:0] CELL_MIN_RST = 13'd3300;
    localparam logic [CFG_W-1:0] CELL_MAX_RST = 13'd4300;

    localparam int LADDER_N = 10;
    localparam logic [MV_W-1:0] LADDER_MV [LADDER_N] = '{
        15'd4050, 15'd3900, 15'd3830, 15'd3770, 15'd3700,
        15'd3630, 15'd3570, 15'd3500, 15'd3430, 15'd3350
    };
    localparam logic [PCT_W-1:0] LADDER_PCT [LADDER_N] = '{
        7'd100, 7'd90, 7'd80, 7'd70, 7'd60, 7'd50, 7'd40, 7'd30, 7'd20, 7'd10
    };
    localparam logic [PCT_W-1:0] PCT_FLOOR = 7'd5;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCALE_MUL,
        S_SCALE_RECIP,
        S_DECIDE,
        S_DIV,
        S_CHECK,
        S_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic scale_mul;
        logic scale_recip;
        logic div_first;
        logic div_next;
        logic div_cells;
        logic div_step;
        logic cells_latch;
        logic pct_zero;
        logic pct_ladder;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic cells_zero;
        logic elapsed;
        logic div_last;
        logic in_window;
        logic trial_last;
        logic out_free;
    } t_status;

    // first threshold exceeded wins; compares are independent
    function automatic logic [PCT_W-1:0] percent_of(input logic [MV_W-1:0] v);
        logic [PCT_W-1:0] pct;
        pct = PCT_FLOOR;
        for (int k = LADDER_N - 1; k >= 0; k--) begin
            if (v > LADDER_MV[k]) begin
                pct = LADDER_PCT[k];
            end
        end
        return pct;
    endfunction

endpackage

// ===== rtl/lpg_ctrl.sv =====
// ----------------------------------------------------------------------------
// lpg_ctrl
// Sequencer: scaling, cell count trials, per-cell divide and result handoff.
// ----------------------------------------------------------------------------
module lpg_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  lpg_pkg::t_status i_status,
    output lpg_pkg::t_cmd   o_cmd
);
    import lpg_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCALE_MUL;
                end
            end
            S_SCALE_MUL: begin
                o_cmd.scale_mul = 1'b1;
                n_state         = S_SCALE_RECIP;
            end
            S_SCALE_RECIP: begin
                o_cmd.scale_recip = 1'b1;
                n_state           = S_DECIDE;
            end
            S_DECIDE: begin
                if (!i_status.cells_zero) begin
                    o_cmd.div_cells = 1'b1;
                    n_state         = S_DIV;
                end else if (i_status.elapsed) begin
                    o_cmd.div_first = 1'b1;
                    n_state         = S_DIV;
                end else begin
                    o_cmd.pct_zero = 1'b1;
                    n_state        = S_OUT;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (!i_status.cells_zero) begin
                    o_cmd.pct_ladder = 1'b1;
                    n_state          = S_OUT;
                end else if (i_status.in_window) begin
                    o_cmd.cells_latch = 1'b1;
                    o_cmd.pct_ladder  = 1'b1;
                    n_state           = S_OUT;
                end else if (i_status.trial_last) begin
                    o_cmd.pct_zero = 1'b1;
                    n_state        = S_OUT;
                end else begin
                    o_cmd.div_next = 1'b1;
                    n_state        = S_DIV;
                end
            end
            S_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/lpg_dp.sv =====
// ----------------------------------------------------------------------------
// lpg_dp
// Datapath: millivolt scaling, bit-serial divider, window test, charge ladder,
// configuration registers and the output register.
// ----------------------------------------------------------------------------
module lpg_dp #(
    parameter int MAX_CELLS = 6
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  lpg_pkg::t_cmd                   i_cmd,
    output lpg_pkg::t_status                o_status,
    input  logic [lpg_pkg::SAMPLE_W-1:0]    i_battery_sample,
    input  logic                            i_startup_elapsed,
    input  logic                            i_cfg_we,
    input  logic [lpg_pkg::ADDR_W-1:0]      i_cfg_addr,
    input  logic [lpg_pkg::CFG_W-1:0]       i_cfg_wdata,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [lpg_pkg::MV_W-1:0]        o_battery_mv,
    output logic [lpg_pkg::CNT_W-1:0]       o_cell_count,
    output logic [lpg_pkg::PCT_W-1:0]       o_remaining_percent
);
    import lpg_pkg::*;

    logic [CFG_W-1:0]     r_cell_min;
    logic [CFG_W-1:0]     r_cell_max;
    logic [CNT_W-1:0]     r_cells;
    logic [SAMPLE_W-1:0]  r_sample;
    logic                 r_elapsed;
    logic [PROD_W-1:0]    r_prod;
    logic [MV_W-1:0]      r_mv;
    logic [CNT_W-1:0]     r_divisor;
    logic [CNT_W-1:0]     r_rem;
    logic [MV_W-1:0]      r_quo;
    logic [DIV_CNT_W-1:0] r_div_cnt;
    logic [PCT_W-1:0]     r_pct;
    logic                 r_out_valid;
    logic [MV_W-1:0]      r_out_mv;
    logic [CNT_W-1:0]     r_out_cells;
    logic [PCT_W-1:0]     r_out_pct;

    logic [PROD_W-1:0]  prod_c;
    logic [WIDE_W-1:0]  wide_c;
    logic [CNT_W:0]     div_part;
    logic [CNT_W:0]     div_diff;
    logic               div_fits;
    logic [CNT_W-1:0]   divisor_c;

    assign prod_c = PROD_W'(r_sample) * PROD_W'(MV_MUL_RED);
    assign wide_c = WIDE_W'(r_prod) * WIDE_W'(MV_RECIP);

    // restoring divide, one quotient bit per cycle
    assign div_part = {r_rem, r_quo[MV_W-1]};
    assign div_fits = div_part >= {1'b0, r_divisor};
    assign div_diff = div_part - {1'b0, r_divisor};

    always_comb begin
        divisor_c = r_cells;
        if (i_cmd.div_first) begin
            divisor_c = CNT_W'(1);
        end else if (i_cmd.div_next) begin
            divisor_c = r_divisor + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_min <= CELL_MIN_RST;
            r_cell_max <= CELL_MAX_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_CELL_MIN: r_cell_min <= i_cfg_wdata;
                REG_CELL_MAX: r_cell_max <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cells <= '0;
        end else if (i_cmd.cells_latch) begin
            r_cells <= r_divisor;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sample  <= i_battery_sample;
            r_elapsed <= i_startup_elapsed;
        end
        if (i_cmd.scale_mul) begin
            r_prod <= prod_c;
        end
        if (i_cmd.scale_recip) begin
            r_mv <= wide_c[RECIP_SHIFT +: MV_W];
        end
        if (i_cmd.div_first || i_cmd.div_next || i_cmd.div_cells) begin
            r_divisor <= divisor_c;
            r_rem     <= '0;
            r_quo     <= r_mv;
            r_div_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_div_cnt <= r_div_cnt + DIV_CNT_W'(1);
            r_quo     <= {r_quo[MV_W-2:0], div_fits};
            r_rem     <= div_fits ? div_diff[CNT_W-1:0] : div_part[CNT_W-1:0];
        end
        if (i_cmd.pct_zero) begin
            r_pct <= '0;
        end else if (i_cmd.pct_ladder) begin
            r_pct <= percent_of(r_quo);
        end
        if (i_cmd.out_load) begin
            r_out_mv    <= r_mv;
            r_out_cells <= i_cmd.cells_latch ? r_divisor : r_cells;
            r_out_pct   <= r_pct;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_status.cells_zero = (r_cells == '0);
    assign o_status.elapsed    = r_elapsed;
    assign o_status.div_last   = (r_div_cnt == DIV_CNT_W'(MV_W - 1));
    assign o_status.in_window  = (r_quo > MV_W'(r_cell_min)) && (r_quo < MV_W'(r_cell_max));
    assign o_status.trial_last = (r_divisor == CNT_W'(MAX_CELLS));
    assign o_status.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid         = r_out_valid;
    assign o_battery_mv        = r_out_mv;
    assign o_cell_count        = r_out_cells;
    assign o_remaining_percent = r_out_pct;

endmodule

// ===== rtl/lipo_battery_gauge.sv =====
// ----------------------------------------------------------------------------
// lipo_battery_gauge
// LiPo cell count detection and remaining-charge estimate from an ADC sample.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready) takes one 12-bit battery sample and
// the startup flag per transaction. Output channel (o_out_valid / i_out_ready)
// returns exactly one transaction per input: millivolts, latched cell count
// and charge percent. Thresholds are written through the plain write port
// (i_cfg_we, i_cfg_addr, i_cfg_wdata). The user must write them only while the
// block is idle; the block itself does not enforce this. One item at a time.
// Scaling multiplies by the reduced factor and then by the reciprocal; each
// divide by a cell count then runs in the bit-serial divider and is followed
// by a check. An item needs one divide once the count is latched, up to
// MAX_CELLS while detecting, and none when the count is unknown and the
// startup flag is low. The divider is the limit in normal operation.
// The result goes to an output register, so the block takes the next item
// while the previous result waits; a stalled receiver holds the sequencer
// only when a second result is ready to be handed over.
// Reset (synchronous, active low) clears the count to unknown, restores the
// window to 3300..4300 mV and drops any pending result.
// ----------------------------------------------------------------------------
`include "lipo_battery_gauge_macros.svh"

module lipo_battery_gauge #(
    parameter int MAX_CELLS = 6
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [lpg_pkg::SAMPLE_W-1:0]    i_battery_sample,
    input  logic                            i_startup_elapsed,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [lpg_pkg::MV_W-1:0]        o_battery_mv,
    output logic [lpg_pkg::CNT_W-1:0]       o_cell_count,
    output logic [lpg_pkg::PCT_W-1:0]       o_remaining_percent,
    input  logic                            i_cfg_we,
    input  logic [lpg_pkg::ADDR_W-1:0]      i_cfg_addr,
    input  logic [lpg_pkg::CFG_W-1:0]       i_cfg_wdata
);
    import lpg_pkg::*;

    t_cmd    cmd;
    t_status status;

    lpg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    lpg_dp #(
        .MAX_CELLS (MAX_CELLS)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_status            (status),
        .i_battery_sample    (i_battery_sample),
        .i_startup_elapsed   (i_startup_elapsed),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_addr          (i_cfg_addr),
        .i_cfg_wdata         (i_cfg_wdata),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_battery_mv        (o_battery_mv),
        .o_cell_count        (o_cell_count),
        .o_remaining_percent (o_remaining_percent)
    );

    // once latched, the cell count holds until reset
    `LPG_ASSERT_NEXT(a_cells_sticky, i_clk, i_rst_n, !status.cells_zero, !status.cells_zero, "cell count changed after latch")
    // an accepted transaction keeps the input side closed while it is worked
    `LPG_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready, "input accepted while busy")
    // a new result appears only through the sequencer handoff
    `LPG_ASSERT_SAME(a_out_from_load, i_clk, i_rst_n, $rose(o_out_valid), $past(cmd.out_load), "result without handoff")
    `LPG_ASSERT_SAME(a_count_range, i_clk, i_rst_n, o_out_valid, o_cell_count <= CNT_W'(MAX_CELLS), "cell count out of range")

endmodule

// ===== tb/tb_lipo_battery_gauge.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lipo_battery_gauge
// Self-checking testbench for the LiPo cell count and charge gauge.
// ----------------------------------------------------------------------------
// A scripted pass covers the field extremes, the empty and inverted windows,
// and detection with the startup flag low. Random passes follow:
// first with the count still unknown, then with samples aimed at the charge
// ladder of the latched count, then with window extremes. Each transaction is
// predicted at acceptance and each reading is compared field by field.
// ----------------------------------------------------------------------------

module tb_lipo_battery_gauge;

    localparam int          CELLS_MAX    = 6;
    localparam int unsigned MV_SCALE_NUM = 28000;
    localparam int unsigned MV_SCALE_DEN = 4635;
    localparam int          SCRIPT_LEN   = 22;
    localparam int          DRAIN_CYCLES = 120;

    typedef struct packed {
        logic [lpg_pkg::MV_W-1:0]  mv;
        logic [lpg_pkg::CNT_W-1:0] cells;
        logic [lpg_pkg::PCT_W-1:0] pct;
    } t_gauge_reading;

    typedef enum bit {ROW_ITEM, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind                    kind;
        logic [lpg_pkg::ADDR_W-1:0]   reg_addr;
        logic [lpg_pkg::CFG_W-1:0]    reg_data;
        logic [lpg_pkg::SAMPLE_W-1:0] sample;
        logic                         elapsed;
        bit                           typed;
        t_gauge_reading               want;
    } t_script_row;

    typedef enum {PH_UNKNOWN_COUNT, PH_LADDER, PH_EXTREMES} t_phase;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_in_valid;
    logic                          o_in_ready;
    logic [lpg_pkg::SAMPLE_W-1:0]  i_battery_sample;
    logic                          i_startup_elapsed;
    logic                          o_out_valid;
    logic                          i_out_ready = 1'b0;
    logic [lpg_pkg::MV_W-1:0]      o_battery_mv;
    logic [lpg_pkg::CNT_W-1:0]     o_cell_count;
    logic [lpg_pkg::PCT_W-1:0]     o_remaining_percent;
    logic                          i_cfg_we;
    logic [lpg_pkg::ADDR_W-1:0]    i_cfg_addr;
    logic [lpg_pkg::CFG_W-1:0]     i_cfg_wdata;

    // predictor state
    logic [lpg_pkg::CFG_W-1:0]     window_lo_mv = lpg_pkg::CELL_MIN_RST;
    logic [lpg_pkg::CFG_W-1:0]     window_hi_mv = lpg_pkg::CELL_MAX_RST;
    logic [lpg_pkg::CNT_W-1:0]     latched_cells = '0;

    t_gauge_reading expected_readings[$];
    t_script_row    script [SCRIPT_LEN];

    int snd_idle_pct = 19;
    int rcv_idle_pct = 56;
    int n_mismatch   = 0;
    int n_samples    = 0;
    int n_readings   = 0;
    int n_reg_writes = 0;

    lipo_battery_gauge #(
        .MAX_CELLS(CELLS_MAX)
    ) dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_battery_sample   (i_battery_sample),
        .i_startup_elapsed  (i_startup_elapsed),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_battery_mv       (o_battery_mv),
        .o_cell_count       (o_cell_count),
        .o_remaining_percent(o_remaining_percent),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_addr         (i_cfg_addr),
        .i_cfg_wdata        (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("lipo_battery_gauge regression: fail");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic logic [lpg_pkg::PCT_W-1:0] charge_pct(input int unsigned v);
        logic [lpg_pkg::PCT_W-1:0] p;
        if (v > 4050)      p = 7'd100;
        else if (v > 3900) p = 7'd90;
        else if (v > 3830) p = 7'd80;
        else if (v > 3770) p = 7'd70;
        else if (v > 3700) p = 7'd60;
        else if (v > 3630) p = 7'd50;
        else if (v > 3570) p = 7'd40;
        else if (v > 3500) p = 7'd30;
        else if (v > 3430) p = 7'd20;
        else if (v > 3350) p = 7'd10;
        else               p = 7'd5;
        return p;
    endfunction

    function automatic t_gauge_reading gauge_predict(
        input logic [lpg_pkg::SAMPLE_W-1:0] s,
        input logic                         elapsed
    );
        t_gauge_reading r;
        int unsigned    mv;
        int unsigned    per;
        bit             hit;
        mv  = (32'(s) * MV_SCALE_NUM) / MV_SCALE_DEN;
        hit = 1'b0;
        // first count whose per-cell voltage sits strictly inside the window
        if (latched_cells == '0 && elapsed) begin
            for (int n = 1; n <= CELLS_MAX; n++) begin
                per = mv / n;
                if (!hit && per > window_lo_mv && per < window_hi_mv) begin
                    latched_cells = lpg_pkg::CNT_W'(n);
                    hit = 1'b1;
                end
            end
        end
        r.mv    = lpg_pkg::MV_W'(mv);
        r.cells = latched_cells;
        r.pct   = (latched_cells == '0) ? '0 : charge_pct(mv / latched_cells);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (expected_readings.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(
        input logic [lpg_pkg::ADDR_W-1:0] addr,
        input logic [lpg_pkg::CFG_W-1:0]  data
    );
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        case (addr)
            lpg_pkg::REG_CELL_MIN: window_lo_mv = data;
            lpg_pkg::REG_CELL_MAX: window_hi_mv = data;
            default: ;
        endcase
        n_reg_writes++;
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_item(
        input logic [lpg_pkg::SAMPLE_W-1:0] s,
        input logic                         elapsed,
        input bit                           typed,
        input t_gauge_reading               fixed
    );
        t_gauge_reading r;
        while ($urandom_range(99) < snd_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_battery_sample  <= s;
        i_startup_elapsed <= elapsed;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        r = gauge_predict(s, elapsed);
        expected_readings.push_back(typed ? fixed : r);
        n_samples++;
    endtask

    // aim most samples at the ladder range of the (expected) cell count
    function automatic logic [lpg_pkg::SAMPLE_W-1:0] pick_sample(input bit aimed);
        int unsigned c;
        int unsigned v;
        int unsigned s;
        if (!aimed || $urandom_range(4) == 0) return lpg_pkg::SAMPLE_W'($urandom_range(0, 4095));
        c = (latched_cells != '0) ? latched_cells : 3;
        v = $urandom_range(3250, 4150);
        s = (v * c * MV_SCALE_DEN) / MV_SCALE_NUM + $urandom_range(0, 1);
        return (s > 4095) ? 12'd4095 : lpg_pkg::SAMPLE_W'(s);
    endfunction

    task automatic retune_window(input t_phase ph);
        logic [lpg_pkg::CFG_W-1:0] lo;
        logic [lpg_pkg::CFG_W-1:0] hi;
        lo = lpg_pkg::CELL_MIN_RST;
        hi = lpg_pkg::CELL_MAX_RST;
        case (ph)
            PH_UNKNOWN_COUNT: begin
                case ($urandom_range(3))
                    0: begin  // empty
                        lo = lpg_pkg::CFG_W'($urandom_range(0, 8191));
                        hi = lo + lpg_pkg::CFG_W'($urandom_range(0, 1));
                    end
                    1: begin  // inverted
                        hi = lpg_pkg::CFG_W'($urandom_range(0, 4000));
                        lo = lpg_pkg::CFG_W'($urandom_range(hi, 8191));
                    end
                    2: begin  // narrow, rarely hit
                        lo = lpg_pkg::CFG_W'($urandom_range(0, 5000));
                        hi = lo + lpg_pkg::CFG_W'($urandom_range(2, 40));
                    end
                    default: begin
                        lo = lpg_pkg::CFG_W'($urandom_range(0, 8191));
                        hi = lpg_pkg::CFG_W'($urandom_range(0, 8191));
                    end
                endcase
            end
            PH_LADDER: begin
                // window no longer matters once latched
                if (latched_cells != '0) begin
                    lo = lpg_pkg::CFG_W'($urandom_range(0, 8191));
                    hi = lpg_pkg::CFG_W'($urandom_range(0, 8191));
                end
            end
            default: begin
                case ($urandom_range(2))
                    0: begin lo = '0;      hi = '1;      end
                    1: begin lo = 13'd5000; hi = 13'd5000; end
                    default: begin lo = '1; hi = '0; end
                endcase
            end
        endcase
        write_reg(lpg_pkg::REG_CELL_MIN, lo);
        write_reg(lpg_pkg::REG_CELL_MAX, hi);
    endtask

    task automatic run_random(input t_phase ph, input int count);
        logic [lpg_pkg::SAMPLE_W-1:0] s;
        logic                         f;
        for (int i = 0; i < count; i++) begin
            if (i % 25 == 0) begin
                retune_window(ph);
            end else if ($urandom_range(39) == 0) begin
                drain_results();
            end
            s = pick_sample(ph != PH_UNKNOWN_COUNT);
            f = (ph == PH_UNKNOWN_COUNT) ? ($urandom_range(99) < 40)
                                         : ($urandom_range(99) < 80);
            send_item(s, f, 1'b0, '0);
        end
    endtask

    function automatic t_script_row cfg_row(
        input logic [lpg_pkg::ADDR_W-1:0] addr,
        input logic [lpg_pkg::CFG_W-1:0]  data
    );
        t_script_row r;
        r          = '0;
        r.kind     = ROW_CFG;
        r.reg_addr = addr;
        r.reg_data = data;
        return r;
    endfunction

    function automatic t_script_row item_row(
        input logic [lpg_pkg::SAMPLE_W-1:0] s,
        input logic                         elapsed
    );
        t_script_row r;
        r         = '0;
        r.kind    = ROW_ITEM;
        r.sample  = s;
        r.elapsed = elapsed;
        return r;
    endfunction

    function automatic t_script_row fixed_row(
        input logic [lpg_pkg::SAMPLE_W-1:0] s,
        input logic                         elapsed,
        input logic [lpg_pkg::MV_W-1:0]     mv,
        input logic [lpg_pkg::CNT_W-1:0]    cells,
        input logic [lpg_pkg::PCT_W-1:0]   pct
    );
        t_script_row r;
        r            = item_row(s, elapsed);
        r.typed      = 1'b1;
        r.want.mv    = mv;
        r.want.cells = cells;
        r.want.pct   = pct;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Receiver and reading checker
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end

    always @(posedge i_clk) begin
        t_gauge_reading want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            n_readings++;
            if (expected_readings.size() == 0) begin
                $display("%0t: unexpected reading mv=%0d cells=%0d pct=%0d", $time,
                         o_battery_mv, o_cell_count, o_remaining_percent);
                n_mismatch++;
            end else begin
                want = expected_readings.pop_front();
                if (o_battery_mv !== want.mv) begin
                    $display("%0t: battery_mv expected %0d actual %0d", $time,
                             want.mv, o_battery_mv);
                    n_mismatch++;
                end
                if (o_cell_count !== want.cells) begin
                    $display("%0t: cell_count expected %0d actual %0d", $time,
                             want.cells, o_cell_count);
                    n_mismatch++;
                end
                if (o_remaining_percent !== want.pct) begin
                    $display("%0t: remaining_percent expected %0d actual %0d", $time,
                             want.pct, o_remaining_percent);
                    n_mismatch++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n           = 1'b0;
        i_in_valid        = 1'b0;
        i_battery_sample  = '0;
        i_startup_elapsed = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_addr        = lpg_pkg::REG_CELL_MIN;
        i_cfg_wdata       = '0;

        // count must stay unknown through the whole script
        script[0]  = fixed_row(12'd0,    1'b0, 15'd0,     3'd0, 7'd0);
        script[1]  = fixed_row(12'd4095, 1'b0, 15'd24737, 3'd0, 7'd0);
        script[2]  = item_row(12'd2048, 1'b0);
        script[3]  = item_row(12'd2047, 1'b0);
        script[4]  = item_row(12'd2000, 1'b0);   // would qualify, flag low
        script[5]  = item_row(12'd400,  1'b1);   // no count fits the window
        script[6]  = cfg_row(lpg_pkg::REG_CELL_MIN, 13'd4300);
        script[7]  = fixed_row(12'd4095, 1'b1, 15'd24737, 3'd0, 7'd0);
        script[8]  = cfg_row(lpg_pkg::REG_CELL_MAX, 13'd4301);
        script[9]  = item_row(12'd2836, 1'b1);   // window with adjacent bounds, still empty
        script[10] = cfg_row(lpg_pkg::REG_CELL_MIN, 13'd8191);
        script[11] = cfg_row(lpg_pkg::REG_CELL_MAX, 13'd0);
        script[12] = item_row(12'd1365, 1'b1);   // inverted window
        script[13] = fixed_row(12'd4095, 1'b1, 15'd24737, 3'd0, 7'd0);
        script[14] = cfg_row(lpg_pkg::REG_CELL_MIN, 13'd0);
        script[15] = cfg_row(lpg_pkg::REG_CELL_MAX, 13'd5000);
        script[16] = fixed_row(12'd0,    1'b1, 15'd0,     3'd0, 7'd0);
        script[17] = cfg_row(lpg_pkg::REG_CELL_MIN, 13'd3300);
        script[18] = cfg_row(lpg_pkg::REG_CELL_MAX, 13'd4300);
        script[19] = item_row(12'd1,    1'b1);
        script[20] = item_row(12'd2730, 1'b0);
        script[21] = item_row(12'd1365, 1'b0);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < SCRIPT_LEN; k++) begin
            if (script[k].kind == ROW_CFG) begin
                write_reg(script[k].reg_addr, script[k].reg_data);
            end else begin
                send_item(script[k].sample, script[k].elapsed, script[k].typed,
                          script[k].want);
            end
        end

        run_random(PH_UNKNOWN_COUNT, 150);

        snd_idle_pct = 56;
        rcv_idle_pct = 19;
        run_random(PH_LADDER, 150);

        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        run_random(PH_EXTREMES, 150);

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d samples, %0d readings checked, %0d register writes, final cell count %0d",
                 n_samples, n_readings, n_reg_writes, latched_cells);
        $display("windows swept empty, inverted, narrow and full range under three idle mixes");
        if (n_mismatch == 0) begin
            $display("lipo_battery_gauge regression: pass");
        end else begin
            $display("lipo_battery_gauge regression: fail");
        end
        $finish;
    end

endmodule
